// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the deframer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define SFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define SFD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the following cycle
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sfd_pkg.sv =====
// shared types and constants of the sensor frame deframer
package sfd_pkg;

	localparam int unsigned IDX_W       = 17;
	localparam logic [IDX_W-1:0] IDX_MAX = '1;
	localparam logic [7:0]  INNER_SEED  = 8'hAA;
	localparam logic [15:0] OUTER_HDR   = 16'd4;
	localparam logic [IDX_W-1:0] MIN_BUF = 17'd8;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned TDATA_W     = 72;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_SHORT      = 3'd1,
		ERR_BAD_HEADER = 3'd2,
		ERR_LEN_SMALL  = 3'd3,
		ERR_TRUNCATED  = 3'd4,
		ERR_DECL_ZERO  = 3'd5,
		ERR_DECL_LONG  = 3'd6
	} err_t;

	// one result item as it travels through the queue
	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [7:0]  command;
		logic [15:0] declared_length;
		logic [7:0]  header_flags;
		logic [15:0] outer_length;
		logic        header_ok;
		logic [7:0]  received_checksum;
		logic        checksum_ok;
		logic        frame_valid;
		err_t        error_code;
	} result_t;

endpackage

// ===== hw/rtl/sfd_front.sv =====
// front end: parses input beats and classifies them into queue entries
module sfd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // data_byte
	input  logic              s_tlast,   // buffer_end
	input  logic              q_full,
	output logic              push,
	output sfd_pkg::result_t  push_data
);
	import sfd_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic [7:0]  flags_q;
	logic [15:0] len_q;
	logic        hdr_good_q;
	logic [7:0]  cmd_q;
	logic [15:0] decl_q;
	logic [7:0]  sum_q;
	logic [7:0]  ck_q;
	logic        done_q;

	logic        accept;
	logic [7:0]  b;
	logic [7:0]  flags_n;
	logic [15:0] len_n;
	logic        hdr_good_n;
	logic [7:0]  cmd_n;
	logic [15:0] decl_n;
	logic [7:0]  hdr_sum;
	logic [7:0]  sum_a;
	logic [7:0]  sum_b;
	logic [7:0]  ck_n;
	logic        outer_ok;
	logic        decl_ok;
	logic        in_payload;
	logic        at_end;
	logic [IDX_W-1:0] len_x;
	logic [IDX_W-1:0] decl_x;
	result_t     res;
	logic        res_valid;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && !q_full;
	assign b        = s_tdata;

	// header fields, command and inner length captured at fixed byte positions
	always_comb begin
		flags_n    = (idx_q == 17'd0) ? b : flags_q;
		len_n      = len_q;
		if (idx_q == 17'd1) len_n = {len_q[15:8], b};
		if (idx_q == 17'd2) len_n = {b, len_q[7:0]};
		hdr_sum    = flags_q + len_q[7:0] + len_q[15:8];
		hdr_good_n = (idx_q == 17'd3) ? (b == hdr_sum) : hdr_good_q;
		cmd_n      = (idx_q == 17'd4) ? b : cmd_q;
		decl_n     = decl_q;
		if (idx_q == 17'd5) decl_n = {decl_q[15:8], b};
		if (idx_q == 17'd6) decl_n = {b, decl_q[7:0]};
	end

	// frame position checks and running inner sum
	always_comb begin
		len_x      = {1'b0, len_n};
		decl_x     = {1'b0, decl_n};
		sum_a      = (idx_q >= 17'd4 && idx_q <= 17'd6) ? sum_q + b : sum_q;
		outer_ok   = hdr_good_n && (len_n >= OUTER_HDR);
		decl_ok    = outer_ok && (decl_n != 16'd0) && (decl_x + 17'd3 <= len_x);
		in_payload = decl_ok && (idx_q >= 17'd7) && (idx_q <= decl_x + 17'd5);
		sum_b      = in_payload ? sum_a + b : sum_a;
		ck_n       = (decl_ok && idx_q == decl_x + 17'd6) ? b : ck_q;
		at_end     = outer_ok && (idx_q >= 17'd7) && (idx_q == len_x + 17'd3);
	end

	// classify the beat into a payload, a status or nothing
	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (done_q) begin
			res_valid = 1'b0;
		end else if (at_end) begin
			res_valid        = 1'b1;
			res.kind         = KIND_STATUS;
			res.header_flags = flags_n;
			res.outer_length = len_n;
			res.header_ok    = hdr_good_n;
			if (decl_n == 16'd0) begin
				res.error_code = ERR_DECL_ZERO;
			end else if (!decl_ok) begin
				res.error_code = ERR_DECL_LONG;
			end else begin
				res.command           = cmd_n;
				res.declared_length   = decl_n;
				res.received_checksum = ck_n;
				res.checksum_ok       = ((INNER_SEED - sum_b) == ck_n);
				res.frame_valid       = 1'b1;
				res.error_code        = ERR_NONE;
			end
		end else if (s_tlast) begin
			res_valid = 1'b1;
			res.kind  = KIND_STATUS;
			// compare against the bound minus one so a saturated count cannot wrap
			if (idx_q < (MIN_BUF - 17'd1)) begin
				res.error_code = ERR_SHORT;
			end else begin
				res.header_flags = flags_n;
				res.outer_length = len_n;
				res.header_ok    = hdr_good_n;
				if (!hdr_good_n)
					res.error_code = ERR_BAD_HEADER;
				else if (len_n < OUTER_HDR)
					res.error_code = ERR_LEN_SMALL;
				else
					res.error_code = ERR_TRUNCATED;
			end
		end else if (in_payload) begin
			res_valid        = 1'b1;
			res.kind         = KIND_PAYLOAD;
			res.payload_byte = b;
		end
	end

	assign push      = accept && res_valid;
	assign push_data = res;

	// parser state, cleared after the last beat of a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			flags_q    <= '0;
			len_q      <= '0;
			hdr_good_q <= 1'b0;
			cmd_q      <= '0;
			decl_q     <= '0;
			sum_q      <= '0;
			ck_q       <= '0;
			done_q     <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				idx_q      <= '0;
				flags_q    <= '0;
				len_q      <= '0;
				hdr_good_q <= 1'b0;
				cmd_q      <= '0;
				decl_q     <= '0;
				sum_q      <= '0;
				ck_q       <= '0;
				done_q     <= 1'b0;
			end else if (!done_q) begin
				if (idx_q != IDX_MAX)
					idx_q <= idx_q + 17'd1;
				flags_q    <= flags_n;
				len_q      <= len_n;
				hdr_good_q <= hdr_good_n;
				cmd_q      <= cmd_n;
				decl_q     <= decl_n;
				sum_q      <= sum_b;
				ck_q       <= ck_n;
				done_q     <= at_end;
			end
		end
	end

endmodule

// ===== hw/rtl/sfd_queue.sv =====
// short result queue between the parser and the output stage
module sfd_queue #(
	parameter int unsigned DEPTH = sfd_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sfd_pkg::result_t  push_data,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output sfd_pkg::result_t  rd_data
);
	import sfd_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	result_t       mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`include "assert_macros.svh"

	`SFD_ASSERT(a_count_range, count_q <= FULL_CNT, "queue count above depth")
	`SFD_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
	`SFD_ASSERT_IMP(a_no_pop_empty, pop, not_empty, "pop from empty queue")
	`SFD_ASSERT_NEXT(a_push_fills, push && !pop, not_empty, "pushed entry lost")

endmodule

// ===== hw/rtl/sfd_back.sv =====
// back end: output register that formats queue entries into result beats
module sfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  sfd_pkg::result_t  q_data,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	// payload_byte, command, declared_length, header_flags, outer_length,
	// header_ok, received_checksum, checksum_ok, frame_valid, error_code
	output logic [sfd_pkg::TDATA_W-1:0] m_tdata,
	output logic              m_tuser    // kind
);
	import sfd_pkg::*;

	logic    out_valid_q;
	result_t out_q;

	assign pop = q_valid && (!out_valid_q || m_tready);

	// output holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= q_data;
	end

	// pack fields from the lowest bit up
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {2'b00,
		out_q.error_code,
		out_q.frame_valid,
		out_q.checksum_ok,
		out_q.received_checksum,
		out_q.header_ok,
		out_q.outer_length,
		out_q.header_flags,
		out_q.declared_length,
		out_q.command,
		out_q.payload_byte};

endmodule

// ===== hw/rtl/sensor_frame_deframer_core.sv =====
// sensor frame deframer top level: parser, result queue and output stage
// Usage:
//   Input beats carry one buffer byte in s_tdata, with s_tlast on the
//   buffer's last byte. Output beats carry a payload byte (m_tuser = 0) or
//   a frame status (m_tuser = 1) in the packed m_tdata word.
//   Each payload byte that passes the header and declared-length checks,
//   bar a buffer's last byte, is one beat; one status beat ends each buffer,
//   and bytes after a completed frame are dropped until the buffer ends.
// Timing:
//   One input beat per cycle while s_tready is high. A result is written
//   into the queue at the edge that accepts its input beat, then, in queue
//   order, into the output register that drives m_tvalid.
//   The parser state updates once per accepted byte.
// Reset and stall:
//   arst_n clears the parser state, the queue and the output register.
//   While m_tready is low the output beat holds and the queue fills; once
//   it holds QUEUE_DEPTH entries, s_tready drops until a slot frees.
module sensor_frame_deframer_core #(
	parameter int unsigned QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // buffer_end
	output logic        m_tvalid,
	input  logic        m_tready,
	// payload_byte, command, declared_length, header_flags, outer_length,
	// header_ok, received_checksum, checksum_ok, frame_valid, error_code
	output logic [sfd_pkg::TDATA_W-1:0] m_tdata,
	output logic        m_tuser    // kind
);
	import sfd_pkg::*;

	logic    q_full;
	logic    q_valid;
	logic    push;
	logic    pop;
	result_t push_data;
	result_t q_data;

	// byte parser and classifier
	sfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	sfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.rd_data   (q_data)
	);

	// output stage
	sfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for the sensor frame deframer core
module tb_top;
	import sfd_pkg::*;

	// one row of the directed stimulus, optionally with a hand-written status
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       fixed_want;
		result_t    want;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;

	// parser state mirrored by the predictor
	logic [IDX_W-1:0] bytes_taken;
	logic [7:0]       hdr_flags;
	logic [15:0]      hdr_len;
	logic             hdr_good;
	logic [7:0]       cmd_byte;
	logic [15:0]      inner_decl;
	logic [7:0]       inner_sum;
	logic [7:0]       inner_ck;
	logic             frame_closed;

	result_t     expected_beats[$];
	logic [7:0]  buffer_bytes[$];
	stim_row_t   directed_rows[$];
	bit          failed = 1'b0;
	bit          no_gaps = 1'b0;
	int unsigned beats_sent = 0;

	sensor_frame_deframer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_parser();
		bytes_taken  = '0;
		hdr_flags    = '0;
		hdr_len      = '0;
		hdr_good     = 1'b0;
		cmd_byte     = '0;
		inner_decl   = '0;
		inner_sum    = '0;
		inner_ck     = '0;
		frame_closed = 1'b0;
	endfunction

	// status beat carrying only outer header values and a code
	function automatic result_t frame_status(input err_t code, input logic [7:0] fl,
			input logic [15:0] len, input logic hok);
		result_t r;
		r = '0;
		r.kind         = KIND_STATUS;
		r.header_flags = fl;
		r.outer_length = len;
		r.header_ok    = hok;
		r.error_code   = code;
		return r;
	endfunction

	// advance the mirrored parser by one byte, return 1 when a beat is due
	function automatic logic step_parser(input logic [7:0] b, input logic last,
			output result_t res);
		int unsigned at, decl, olen;
		logic        outer_ok, decl_ok, emit;
		logic [7:0]  hsum, want_ck;
		res = '0;
		emit = 1'b0;
		if (frame_closed) begin
			if (last)
				clear_parser();
			return 1'b0;
		end
		at = bytes_taken;
		// header, command and inner length capture
		case (at)
			0: hdr_flags = b;
			1: hdr_len[7:0] = b;
			2: hdr_len[15:8] = b;
			3: begin
				hsum = hdr_flags + hdr_len[7:0] + hdr_len[15:8];
				hdr_good = (b == hsum);
			end
			4: cmd_byte = b;
			5: inner_decl[7:0] = b;
			6: inner_decl[15:8] = b;
			default: ;
		endcase
		if (at >= 4 && at <= 6)
			inner_sum = inner_sum + b;
		decl = inner_decl;
		olen = hdr_len;
		outer_ok = hdr_good && hdr_len >= OUTER_HDR;
		decl_ok = outer_ok && decl >= 1 && decl + 3 <= olen;
		// payload bytes, held back on the buffer's last byte
		if (decl_ok && at >= 7 && at <= decl + 5) begin
			inner_sum = inner_sum + b;
			if (!last) begin
				emit = 1'b1;
				res.kind = KIND_PAYLOAD;
				res.payload_byte = b;
			end
		end
		if (decl_ok && at == decl + 6)
			inner_ck = b;
		// end of the outer frame, or buffer end before it
		if (outer_ok && at >= 7 && at == olen + 3) begin
			if (decl == 0) begin
				res = frame_status(ERR_DECL_ZERO, hdr_flags, hdr_len, 1'b1);
			end else if (!decl_ok) begin
				res = frame_status(ERR_DECL_LONG, hdr_flags, hdr_len, 1'b1);
			end else begin
				want_ck = INNER_SEED - inner_sum;
				res = frame_status(ERR_NONE, hdr_flags, hdr_len, 1'b1);
				res.command           = cmd_byte;
				res.declared_length   = inner_decl;
				res.received_checksum = inner_ck;
				res.checksum_ok       = (want_ck == inner_ck);
				res.frame_valid       = 1'b1;
			end
			emit = 1'b1;
			frame_closed = 1'b1;
		end else if (last) begin
			if (at + 1 < MIN_BUF)
				res = frame_status(ERR_SHORT, '0, '0, 1'b0);
			else if (!hdr_good)
				res = frame_status(ERR_BAD_HEADER, hdr_flags, hdr_len, 1'b0);
			else if (hdr_len < OUTER_HDR)
				res = frame_status(ERR_LEN_SMALL, hdr_flags, hdr_len, 1'b1);
			else
				res = frame_status(ERR_TRUNCATED, hdr_flags, hdr_len, 1'b1);
			emit = 1'b1;
		end
		if (bytes_taken != IDX_MAX)
			bytes_taken = bytes_taken + 1'b1;
		if (last)
			clear_parser();
		return emit;
	endfunction

	function automatic stim_row_t row(input logic [7:0] b, input logic last);
		stim_row_t r;
		r = '0;
		r.data = b;
		r.last = last;
		return r;
	endfunction

	// buffer-ending byte with its status written out by hand
	function automatic stim_row_t row_want(input logic [7:0] b, input result_t want);
		stim_row_t r;
		r = row(b, 1'b1);
		r.fixed_want = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic void cmp_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %h, actual %h", name, want, got);
			failed = 1'b1;
		end
	endfunction

	// drive one input beat after a random gap, predict once it is taken
	task automatic send_beat(input logic [7:0] b, input logic last, input logic fixed_want,
			input result_t want);
		int unsigned gap;
		result_t     got;
		logic        has;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		has = step_parser(b, last, got);
		if (fixed_want)
			expected_beats.push_back(want);
		else if (has)
			expected_beats.push_back(got);
		beats_sent++;
	endtask

	// hold the input side until every predicted beat has come out
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0) @(posedge clk);
	endtask

	// output side: random stall per beat, then compare with the oldest prediction
	initial begin
		int unsigned stall;
		result_t     want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if (expected_beats.size() == 0) begin
				$error("beat with nothing expected: kind %0d data %h", m_tuser, m_tdata);
				failed = 1'b1;
			end else begin
				want = expected_beats.pop_front();
				cmp_field("kind", want.kind, m_tuser);
				cmp_field("payload_byte", want.payload_byte, m_tdata[7:0]);
				cmp_field("command", want.command, m_tdata[15:8]);
				cmp_field("declared_length", want.declared_length, m_tdata[31:16]);
				cmp_field("header_flags", want.header_flags, m_tdata[39:32]);
				cmp_field("outer_length", want.outer_length, m_tdata[55:40]);
				cmp_field("header_ok", want.header_ok, m_tdata[56]);
				cmp_field("received_checksum", want.received_checksum, m_tdata[64:57]);
				cmp_field("checksum_ok", want.checksum_ok, m_tdata[65]);
				cmp_field("frame_valid", want.frame_valid, m_tdata[66]);
				cmp_field("error_code", want.error_code, m_tdata[69:67]);
				cmp_field("tdata padding", 16'd0, m_tdata[71:70]);
			end
		end
	end

	// stimulus
	initial begin
		int unsigned pick, olen, decl, n, k;
		logic [7:0]  fl, bv, sum;
		logic        good_ck;

		// single byte buffer
		directed_rows.push_back(row_want(8'hFF, frame_status(ERR_SHORT, '0, '0, 1'b0)));
		// valid frame with two payload bytes and a dropped trailing byte
		directed_rows.push_back(row(8'hA5, 1'b0));
		directed_rows.push_back(row(8'h06, 1'b0));
		directed_rows.push_back(row(8'h00, 1'b0));
		directed_rows.push_back(row(8'hAB, 1'b0));
		directed_rows.push_back(row(8'hFF, 1'b0));
		directed_rows.push_back(row(8'h03, 1'b0));
		directed_rows.push_back(row(8'h00, 1'b0));
		directed_rows.push_back(row(8'h00, 1'b0));
		directed_rows.push_back(row(8'hFF, 1'b0));
		directed_rows.push_back(row(8'hA9, 1'b0));
		directed_rows.push_back(row(8'h5A, 1'b1));
		// header checksum wrong, outer length all ones
		directed_rows.push_back(row(8'h00, 1'b0));
		directed_rows.push_back(row(8'hFF, 1'b0));
		directed_rows.push_back(row(8'hFF, 1'b0));
		directed_rows.push_back(row(8'h00, 1'b0));
		directed_rows.push_back(row(8'h80, 1'b0));
		directed_rows.push_back(row(8'h7F, 1'b0));
		directed_rows.push_back(row(8'h01, 1'b0));
		directed_rows.push_back(row_want(8'hFE,
			frame_status(ERR_BAD_HEADER, 8'h00, 16'hFFFF, 1'b0)));
		// buffer ends on a payload byte
		directed_rows.push_back(row(8'hFF, 1'b0));
		directed_rows.push_back(row(8'h00, 1'b0));
		directed_rows.push_back(row(8'h01, 1'b0));
		directed_rows.push_back(row(8'h00, 1'b0));
		directed_rows.push_back(row(8'h00, 1'b0));
		directed_rows.push_back(row(8'hFD, 1'b0));
		directed_rows.push_back(row(8'h00, 1'b0));
		directed_rows.push_back(row_want(8'h55,
			frame_status(ERR_TRUNCATED, 8'hFF, 16'h0100, 1'b1)));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		clear_parser();

		foreach (directed_rows[r])
			send_beat(directed_rows[r].data, directed_rows[r].last,
				directed_rows[r].fixed_want, directed_rows[r].want);
		wait_for_results();

		// random buffers, mostly well-formed frames
		while (beats_sent < 820) begin
			buffer_bytes.delete();
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// good outer header, inner length valid, zero or too long
				fl = 8'($urandom);
				olen = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 300) :
					$urandom_range(4, 24);
				n = $urandom_range(0, 9);
				if (n == 0)
					decl = 0;
				else if (n == 1)
					decl = $urandom_range(olen - 2, 65535);
				else
					decl = $urandom_range(1, olen - 3);
				good_ck = ($urandom_range(0, 3) != 0);
				buffer_bytes.push_back(fl);
				buffer_bytes.push_back(8'(olen));
				buffer_bytes.push_back(8'(olen >> 8));
				buffer_bytes.push_back(8'(fl + olen + (olen >> 8)));
				bv = 8'($urandom);
				buffer_bytes.push_back(bv);
				buffer_bytes.push_back(8'(decl));
				buffer_bytes.push_back(8'(decl >> 8));
				sum = 8'(bv + decl + (decl >> 8));
				for (k = 7; k <= olen + 3; k++) begin
					bv = 8'($urandom);
					if (k <= decl + 5)
						sum = sum + bv;
					else if (k == decl + 6 && good_ck)
						bv = INNER_SEED - sum;
					buffer_bytes.push_back(bv);
				end
				repeat ($urandom_range(0, 3)) buffer_bytes.push_back(8'($urandom));
				// cut some buffers short anywhere
				if ($urandom_range(0, 6) == 0) begin
					n = $urandom_range(1, buffer_bytes.size());
					while (buffer_bytes.size() > n) void'(buffer_bytes.pop_back());
				end
			end else if (pick < 70) begin
				// good header with an outer length under four
				fl = 8'($urandom);
				olen = $urandom_range(0, 3);
				buffer_bytes.push_back(fl);
				buffer_bytes.push_back(8'(olen));
				buffer_bytes.push_back(8'h00);
				buffer_bytes.push_back(8'(fl + olen));
				repeat ($urandom_range(0, 10)) buffer_bytes.push_back(8'($urandom));
			end else if (pick < 80) begin
				// header checksum off by a nonzero amount
				fl = 8'($urandom);
				olen = $urandom_range(0, 65535);
				buffer_bytes.push_back(fl);
				buffer_bytes.push_back(8'(olen));
				buffer_bytes.push_back(8'(olen >> 8));
				buffer_bytes.push_back(8'(fl + olen + (olen >> 8) + $urandom_range(1, 255)));
				repeat ($urandom_range(0, 14)) buffer_bytes.push_back(8'($urandom));
			end else begin
				// unstructured bytes, short buffers among them
				n = (pick < 90) ? $urandom_range(1, 7) : $urandom_range(1, 30);
				repeat (n) buffer_bytes.push_back(8'($urandom));
			end
			no_gaps = ($urandom_range(0, 9) == 0);
			foreach (buffer_bytes[j])
				send_beat(buffer_bytes[j], j == buffer_bytes.size() - 1, 1'b0, '0);
			no_gaps = 1'b0;
			if ($urandom_range(0, 19) == 0)
				wait_for_results();
		end

		wait_for_results();
		repeat (16) @(posedge clk);
		if (!failed)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// run limit
	initial begin
		#20000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
